// ----- hdl/llgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llgs_pkg
// Shared types and constants for the least loaded gateway select block.
// ----------------------------------------------------------------------------
package llgs_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 16;
   localparam int FULL_MARGIN         = 10;
   localparam logic [15:0] LIMIT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      CMD_INSTALL = 2'd0,
      CMD_UPDATE  = 2'd1,
      CMD_DISABLE = 2'd2,
      CMD_SELECT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      GW_NORMAL          = 2'd0,
      GW_MAINTAIN        = 2'd1,
      GW_NORMAL_MAINTAIN = 2'd2,
      GW_OTHER           = 2'd3
   } gw_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIS_RD,
      S_DIS_WR,
      S_SCAN,
      S_CHECK,
      S_FIN
   } fsm_type;

   typedef struct packed {
      cmd_type      command;
      logic [3:0]   slot;
      logic         entry_present;
      gw_state_type entry_state;
      logic [15:0]  entry_net_type;
      logic [15:0]  entry_port;
      logic [15:0]  entry_online;
      logic [15:0]  request_net_type;
   } req_payload_type;

   typedef struct packed {
      logic        success;
      logic [3:0]  chosen_slot;
      logic [15:0] chosen_net_type;
      logic [15:0] chosen_port;
      logic [15:0] chosen_online;
   } rsp_payload_type;

   typedef struct packed {
      gw_state_type state;
      logic [15:0]  net_type;
      logic [15:0]  port;
      logic [15:0]  online;
   } entry_type;

endpackage
`default_nettype wire

// ----- hdl/llgs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llgs_if
// Valid/ready channels for the request and response items.
// ----------------------------------------------------------------------------
interface llgs_req_if;
   logic                      valid;
   logic                      ready;
   llgs_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface llgs_rsp_if;
   logic                      valid;
   logic                      ready;
   llgs_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/least_loaded_gateway_select.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_gateway_select
// Gateway table with install, update, disable-all and least-loaded select.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command item, rsp_chan returns exactly one response
//   item per command, in order. csr_we/csr_wdata write the per-gateway user
//   limit; write it only while the block is idle.
//   Entry fields live in a single-port-write synchronous RAM (registered
//   read); present flags are flops cleared by reset.
//   One item is in flight at a time. Steps from accept to the next accept:
//     install / update : write the entry, then respond
//     disable all      : read-modify-write per entry, then respond
//     select           : one scan of all slots per pass, one or two passes
//   The scan rate is set by the one RAM read port, one entry per cycle.
//   Reset clears all present flags, restores the limit to 1000 and drops any
//   pending response. A stalled receiver holds the response in the output
//   register; the next item may be accepted meanwhile, and its response waits
//   until the held one is taken.
// ----------------------------------------------------------------------------
module least_loaded_gateway_select #(
   parameter int TABLE_SLOTS = llgs_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   llgs_req_if.sink         req_chan,
   llgs_rsp_if.source       rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   localparam int IW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW  = IW + 1;
   localparam int SXW = (IW > 4) ? IW + 1 : 5;
   localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_SLOTS - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(TABLE_SLOTS);

   llgs_pkg::fsm_type state_ff, state_in;

   llgs_pkg::entry_type mem [TABLE_SLOTS];
   llgs_pkg::entry_type rd_data_ff;
   llgs_pkg::entry_type mem_wdata;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   logic [IW-1:0]       rd_addr;

   logic [TABLE_SLOTS-1:0] present_ff;
   logic [15:0]            limit_ff;

   llgs_pkg::cmd_type cmd_ff;
   logic [15:0]       req_nt_ff;
   logic [CW-1:0]     cnt_ff;
   logic              pass2_ff;
   logic              best_vld_ff;
   logic [IW-1:0]     best_slot_ff;
   logic [15:0]       best_nt_ff;
   logic [15:0]       best_port_ff;
   logic [15:0]       best_onl_ff;
   logic              res_ok_ff;

   logic                      rsp_valid_ff;
   llgs_pkg::rsp_payload_type rsp_data_ff;

   logic             req_ready;
   logic             accept;
   logic [SXW-1:0]   slot_ext;
   logic             in_table;
   logic [IW-1:0]    slot_idx;
   logic [IW-1:0]    eidx;
   logic             cand;
   logic             take;
   logic             full;
   logic             hit;
   logic             load_rsp;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign accept   = req_chan.valid && req_ready;
   assign slot_ext = SXW'(req_chan.data.slot);
   assign in_table = slot_ext < SXW'(TABLE_SLOTS);
   assign slot_idx = slot_ext[IW-1:0];

   // candidate evaluation for the entry read in the previous cycle
   assign eidx = IW'(cnt_ff - CW'(1));
   assign cand = present_ff[eidx] && (rd_data_ff.state == llgs_pkg::GW_NORMAL)
                 && (pass2_ff || (rd_data_ff.net_type == req_nt_ff));
   assign take = cand && (!best_vld_ff || (best_onl_ff >= rd_data_ff.online));
   assign full = ({1'b0, best_onl_ff} + 17'(llgs_pkg::FULL_MARGIN)) >= {1'b0, limit_ff};
   assign hit  = best_vld_ff && !full;
   assign load_rsp = (state_ff == llgs_pkg::S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llgs_pkg::S_IDLE: begin
            if (accept) begin
               case (req_chan.data.command)
                  llgs_pkg::CMD_DISABLE: state_in = llgs_pkg::S_DIS_RD;
                  llgs_pkg::CMD_SELECT:  state_in = llgs_pkg::S_SCAN;
                  default:               state_in = llgs_pkg::S_FIN;
               endcase
            end
         end
         llgs_pkg::S_DIS_RD: state_in = llgs_pkg::S_DIS_WR;
         llgs_pkg::S_DIS_WR: begin
            state_in = (cnt_ff == CNT_LAST) ? llgs_pkg::S_FIN : llgs_pkg::S_DIS_RD;
         end
         llgs_pkg::S_SCAN: begin
            if (cnt_ff == CNT_END) begin
               state_in = llgs_pkg::S_CHECK;
            end
         end
         llgs_pkg::S_CHECK: begin
            state_in = (hit || pass2_ff) ? llgs_pkg::S_FIN : llgs_pkg::S_SCAN;
         end
         llgs_pkg::S_FIN: begin
            if (load_rsp) begin
               state_in = llgs_pkg::S_IDLE;
            end
         end
         default: state_in = llgs_pkg::S_IDLE;
      endcase
   end

   // outputs and ram controls
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = slot_idx;
      mem_wdata = '{state:    req_chan.data.entry_state,
                    net_type: req_chan.data.entry_net_type,
                    port:     req_chan.data.entry_port,
                    online:   req_chan.data.entry_online};
      rd_addr   = cnt_ff[IW-1:0];
      case (state_ff)
         llgs_pkg::S_IDLE: begin
            req_ready = !reset;
            if (req_chan.valid && !reset && in_table) begin
               if (req_chan.data.command == llgs_pkg::CMD_INSTALL) begin
                  mem_we = req_chan.data.entry_present;
               end else if (req_chan.data.command == llgs_pkg::CMD_UPDATE) begin
                  mem_we = present_ff[slot_idx];
               end
            end
         end
         llgs_pkg::S_DIS_WR: begin
            mem_we    = present_ff[cnt_ff[IW-1:0]];
            mem_waddr = cnt_ff[IW-1:0];
            mem_wdata = '{state: (rd_data_ff.state == llgs_pkg::GW_NORMAL_MAINTAIN) ?
                                 llgs_pkg::GW_NORMAL_MAINTAIN : llgs_pkg::GW_MAINTAIN,
                          net_type: rd_data_ff.net_type,
                          port:     16'd0,
                          online:   16'd0};
         end
         default: begin
         end
      endcase
   end

   // entry ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llgs_pkg::S_IDLE;
         present_ff   <= '0;
         limit_ff     <= llgs_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (accept && in_table && (req_chan.data.command == llgs_pkg::CMD_INSTALL)) begin
            present_ff[slot_idx] <= req_chan.data.entry_present;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept || ((state_ff == llgs_pkg::S_CHECK) && !hit && !pass2_ff)) begin
            best_vld_ff <= 1'b0;
         end else if ((state_ff == llgs_pkg::S_SCAN) && (cnt_ff != '0) && take) begin
            best_vld_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         llgs_pkg::S_IDLE: begin
            if (accept) begin
               cmd_ff    <= req_chan.data.command;
               req_nt_ff <= req_chan.data.request_net_type;
               cnt_ff    <= '0;
               pass2_ff  <= 1'b0;
               case (req_chan.data.command)
                  llgs_pkg::CMD_UPDATE: res_ok_ff <= in_table && present_ff[slot_idx];
                  llgs_pkg::CMD_SELECT: res_ok_ff <= 1'b0;
                  default:              res_ok_ff <= 1'b1;
               endcase
            end
         end
         llgs_pkg::S_DIS_WR: cnt_ff <= cnt_ff + CW'(1);
         llgs_pkg::S_SCAN: begin
            cnt_ff <= cnt_ff + CW'(1);
            if ((cnt_ff != '0) && take) begin
               best_slot_ff <= eidx;
               best_nt_ff   <= rd_data_ff.net_type;
               best_port_ff <= rd_data_ff.port;
               best_onl_ff  <= rd_data_ff.online;
            end
         end
         llgs_pkg::S_CHECK: begin
            if (hit) begin
               res_ok_ff <= 1'b1;
            end else if (!pass2_ff) begin
               pass2_ff <= 1'b1;
               cnt_ff   <= '0;
            end else begin
               res_ok_ff <= 1'b0;
            end
         end
         llgs_pkg::S_FIN: begin
            if (load_rsp) begin
               rsp_data_ff.success <= res_ok_ff;
               if ((cmd_ff == llgs_pkg::CMD_SELECT) && res_ok_ff) begin
                  rsp_data_ff.chosen_slot     <= 4'(SXW'(best_slot_ff));
                  rsp_data_ff.chosen_net_type <= best_nt_ff;
                  rsp_data_ff.chosen_port     <= best_port_ff;
                  rsp_data_ff.chosen_online   <= best_onl_ff;
               end else begin
                  rsp_data_ff.chosen_slot     <= '0;
                  rsp_data_ff.chosen_net_type <= '0;
                  rsp_data_ff.chosen_port     <= '0;
                  rsp_data_ff.chosen_online   <= '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/llgs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llgs_checker
// Port-level checks for the least loaded gateway select block.
// ----------------------------------------------------------------------------
module llgs_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire llgs_pkg::rsp_payload_type rsp_data
);

   // held response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one item in flight
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // failed responses carry no gateway
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.success |->
         (rsp_data.chosen_slot == '0) && (rsp_data.chosen_net_type == '0) &&
         (rsp_data.chosen_port == '0) && (rsp_data.chosen_online == '0))
      else $error("failed response carries gateway fields");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind least_loaded_gateway_select llgs_checker u_llgs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
`default_nettype wire
